FILE: sv/omwsm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// omwsm_pkg
// Shared types and constants for the omni wheel speed mixer.
// ----------------------------------------------------------------------------
package omwsm_pkg;

    localparam int IN_W       = 16;
    localparam int COEF_W     = 16;
    localparam int COEF_FRAC  = 14;
    localparam int SL_W       = 10;
    localparam int MAG_W      = 10;
    localparam int CMD_W      = MAG_W + 1;
    localparam int NUM_WHEELS = 3;
    localparam int N_W        = 2 * IN_W;          // x*x + y*y
    localparam int ROOT_W     = N_W / 2;
    localparam int P_W        = 2 * IN_W + 1;      // y*c - x*s
    localparam int AP_W       = P_W - 1;
    localparam int M_W        = SL_W + AP_W;
    localparam int SQ_STAGES  = ROOT_W;
    localparam int DIV_STAGES = MAG_W + 1;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = COEF_W;

    localparam logic [SL_W-1:0]          SPEED_LIMIT_RST = SL_W'(464);
    localparam logic signed [COEF_W-1:0] W1_COS_RST      = 16'sd14399;
    localparam logic signed [COEF_W-1:0] W1_SIN_RST      = 16'sd7818;
    localparam logic signed [COEF_W-1:0] W2_COS_RST      = -16'sd14399;
    localparam logic signed [COEF_W-1:0] W2_SIN_RST      = 16'sd7818;
    localparam logic signed [COEF_W-1:0] W3_COS_RST      = 16'sd0;
    localparam logic signed [COEF_W-1:0] W3_SIN_RST      = -16'sd16384;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SPEED_LIMIT = 3'd0,
        REG_WHEEL1_COS  = 3'd1,
        REG_WHEEL1_SIN  = 3'd2,
        REG_WHEEL2_COS  = 3'd3,
        REG_WHEEL2_SIN  = 3'd4,
        REG_WHEEL3_COS  = 3'd5,
        REG_WHEEL3_SIN  = 3'd6
    } reg_idx_t;

    typedef struct packed {
        logic signed [IN_W-1:0] stick_x;
        logic signed [IN_W-1:0] stick_y;
    } in_t;

    typedef struct packed {
        logic [CMD_W-1:0] wheel1_cmd;
        logic [CMD_W-1:0] wheel2_cmd;
        logic [CMD_W-1:0] wheel3_cmd;
        logic             was_limited;
    } out_t;

    // data that rides alongside the square root
    typedef struct packed {
        logic [NUM_WHEELS-1:0][P_W-1:0] p;
        logic                           lim;
    } side_t;

endpackage

FILE: sv/omwsm_sqrt.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// omwsm_sqrt
// Pipelined integer square root, one result bit per stage, with a side tag.
// ----------------------------------------------------------------------------
module omwsm_sqrt #(
    parameter int NW    = 32,
    parameter int TAG_W = 1
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              vld_in,
    input  logic [NW-1:0]     n_in,
    input  logic [TAG_W-1:0]  tag_in,
    output logic              vld_out,
    output logic [NW/2-1:0]   root_out,
    output logic [TAG_W-1:0]  tag_out
);

    localparam int ST = NW / 2;

    logic [NW:0]      rem_reg  [ST];
    logic [NW:0]      root_reg [ST];
    logic [TAG_W-1:0] tag_reg  [ST];
    logic [ST-1:0]    vld_reg;

    for (genvar gi = 0; gi < ST; gi++) begin : g_stage
        localparam logic [NW:0] BIT = (NW+1)'(1) << (NW - 2 - 2*gi);
        logic [NW:0]      rem_src, root_src, trial, rem_next, root_next;
        logic [TAG_W-1:0] tag_src;
        logic             vld_src;

        if (gi == 0) begin : g_first
            assign rem_src  = (NW+1)'(n_in);
            assign root_src = '0;
            assign tag_src  = tag_in;
            assign vld_src  = vld_in;
        end
        else begin : g_next
            assign rem_src  = rem_reg[gi-1];
            assign root_src = root_reg[gi-1];
            assign tag_src  = tag_reg[gi-1];
            assign vld_src  = vld_reg[gi-1];
        end

        always_comb
        begin
            trial = root_src + BIT;
            if (rem_src >= trial)
            begin
                rem_next  = rem_src - trial;
                root_next = (root_src >> 1) + BIT;
            end
            else
            begin
                rem_next  = rem_src;
                root_next = root_src >> 1;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld_reg[gi] <= 1'b0;
            else
                vld_reg[gi] <= vld_src;
        end

        always_ff @(posedge clk)
        begin
            rem_reg[gi]  <= rem_next;
            root_reg[gi] <= root_next;
            tag_reg[gi]  <= tag_src;
        end
    end

    assign vld_out  = vld_reg[ST-1];
    assign root_out = root_reg[ST-1][NW/2-1:0];
    assign tag_out  = tag_reg[ST-1];

endmodule

FILE: sv/omwsm_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// omwsm_div
// Pipelined restoring divider, three lanes sharing one divisor. The top
// quotient bit flags a result that does not fit the magnitude field.
// ----------------------------------------------------------------------------
module omwsm_div #(
    parameter int WW = 46,
    parameter int DW = 30
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  vld_in,
    input  logic [omwsm_pkg::NUM_WHEELS-1:0][WW-1:0] m_in,
    input  logic [DW-1:0]                         d_in,
    input  logic [omwsm_pkg::NUM_WHEELS-1:0]      neg_in,
    input  logic                                  lim_in,
    output logic                                  vld_out,
    output logic [omwsm_pkg::NUM_WHEELS-1:0][omwsm_pkg::MAG_W:0] q_out,
    output logic [omwsm_pkg::NUM_WHEELS-1:0]      neg_out,
    output logic                                  lim_out
);

    localparam int ST = omwsm_pkg::DIV_STAGES;
    localparam int QW = omwsm_pkg::MAG_W + 1;
    localparam int NL = omwsm_pkg::NUM_WHEELS;

    logic [NL-1:0][WW-1:0] r_reg   [ST];
    logic [NL-1:0][QW-1:0] q_reg   [ST];
    logic [DW-1:0]         d_reg   [ST];
    logic [NL-1:0]         neg_reg [ST];
    logic [ST-1:0]         lim_reg;
    logic [ST-1:0]         vld_reg;

    for (genvar gi = 0; gi < ST; gi++) begin : g_stage
        localparam int K = QW - 1 - gi;
        logic [NL-1:0][WW-1:0] r_src, r_next;
        logic [NL-1:0][QW-1:0] q_src, q_next;
        logic [DW-1:0]         d_src;
        logic [NL-1:0]         neg_src;
        logic                  lim_src, vld_src;
        logic [WW-1:0]         dk;

        if (gi == 0) begin : g_first
            assign r_src   = m_in;
            assign q_src   = '0;
            assign d_src   = d_in;
            assign neg_src = neg_in;
            assign lim_src = lim_in;
            assign vld_src = vld_in;
        end
        else begin : g_next
            assign r_src   = r_reg[gi-1];
            assign q_src   = q_reg[gi-1];
            assign d_src   = d_reg[gi-1];
            assign neg_src = neg_reg[gi-1];
            assign lim_src = lim_reg[gi-1];
            assign vld_src = vld_reg[gi-1];
        end

        assign dk = WW'(d_src) << K;

        always_comb
        begin
            for (int l = 0; l < NL; l++)
            begin
                if (r_src[l] >= dk)
                begin
                    r_next[l] = r_src[l] - dk;
                    q_next[l] = q_src[l] | (QW'(1) << K);
                end
                else
                begin
                    r_next[l] = r_src[l];
                    q_next[l] = q_src[l];
                end
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld_reg[gi] <= 1'b0;
            else
                vld_reg[gi] <= vld_src;
        end

        always_ff @(posedge clk)
        begin
            r_reg[gi]   <= r_next;
            q_reg[gi]   <= q_next;
            d_reg[gi]   <= d_src;
            neg_reg[gi] <= neg_src;
            lim_reg[gi] <= lim_src;
        end
    end

    assign vld_out = vld_reg[ST-1];
    assign q_out   = q_reg[ST-1];
    assign neg_out = neg_reg[ST-1];
    assign lim_out = lim_reg[ST-1];

endmodule

FILE: sv/omni_wheel_speed_mixer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// omni_wheel_speed_mixer
// Three-wheel omni drive inverse kinematics: joystick vector to wheel commands.
// ----------------------------------------------------------------------------
// A joystick sample is taken on any cycle with start high (busy is always low)
// and its wheel commands appear on result with result_valid high for one cycle;
// one sample per cycle is sustained. The pipeline holds the 16-stage square root
// (one root bit per stage) that finds the vector length and the 11-stage divider
// that scales each wheel speed by it when the vector is over unit length; three
// stages in front form the products and two after the root form the scaled
// magnitudes. The result cannot be held off: it must be taken when shown.
module omni_wheel_speed_mixer #(
    parameter int INPUT_FRAC_BITS = 14
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 start,
    output logic                                 busy,
    input  omwsm_pkg::in_t                       sample,
    input  logic                                 wr_en,
    input  logic [omwsm_pkg::CFG_IDX_W-1:0]      wr_index,
    input  logic [omwsm_pkg::CFG_DATA_W-1:0]     wr_data,
    output logic                                 result_valid,
    output omwsm_pkg::out_t                      result
);

    localparam int NL      = omwsm_pkg::NUM_WHEELS;
    localparam int SHIFT   = INPUT_FRAC_BITS + omwsm_pkg::COEF_FRAC;
    localparam int DW      = (SHIFT + 1 > 30) ? SHIFT + 1 : 30;
    localparam int WW      = ((omwsm_pkg::M_W > DW + omwsm_pkg::MAG_W + 1) ?
                              omwsm_pkg::M_W : DW + omwsm_pkg::MAG_W + 1) + 1;
    localparam int LATENCY = 3 + omwsm_pkg::SQ_STAGES + 2 + omwsm_pkg::DIV_STAGES + 1;
    localparam logic [63:0] LIM_THR = 64'(1) << (2 * INPUT_FRAC_BITS);
    localparam int TAG_W   = $bits(omwsm_pkg::side_t);

    // ---------------- configuration ----------------
    logic [omwsm_pkg::SL_W-1:0]          speed_limit_reg;
    logic signed [omwsm_pkg::COEF_W-1:0] cos_reg [NL];
    logic signed [omwsm_pkg::COEF_W-1:0] sin_reg [NL];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            speed_limit_reg <= omwsm_pkg::SPEED_LIMIT_RST;
            cos_reg[0]      <= omwsm_pkg::W1_COS_RST;
            sin_reg[0]      <= omwsm_pkg::W1_SIN_RST;
            cos_reg[1]      <= omwsm_pkg::W2_COS_RST;
            sin_reg[1]      <= omwsm_pkg::W2_SIN_RST;
            cos_reg[2]      <= omwsm_pkg::W3_COS_RST;
            sin_reg[2]      <= omwsm_pkg::W3_SIN_RST;
        end
        else if (wr_en)
        begin
            unique case (wr_index)
                omwsm_pkg::REG_SPEED_LIMIT: speed_limit_reg <= wr_data[omwsm_pkg::SL_W-1:0];
                omwsm_pkg::REG_WHEEL1_COS:  cos_reg[0] <= wr_data;
                omwsm_pkg::REG_WHEEL1_SIN:  sin_reg[0] <= wr_data;
                omwsm_pkg::REG_WHEEL2_COS:  cos_reg[1] <= wr_data;
                omwsm_pkg::REG_WHEEL2_SIN:  sin_reg[1] <= wr_data;
                omwsm_pkg::REG_WHEEL3_COS:  cos_reg[2] <= wr_data;
                omwsm_pkg::REG_WHEEL3_SIN:  sin_reg[2] <= wr_data;
                default: ;
            endcase
        end
    end

    assign busy = 1'b0;

    // ---------------- front stages ----------------
    logic                               v1_reg, v2_reg, v3_reg;
    omwsm_pkg::in_t                     s1_reg;
    logic [omwsm_pkg::N_W-1:0]          xx_reg, yy_reg;
    logic signed [omwsm_pkg::N_W-1:0]   yc_reg [NL];
    logic signed [omwsm_pkg::N_W-1:0]   xs_reg [NL];
    logic [omwsm_pkg::N_W-1:0]          n_reg;
    omwsm_pkg::side_t                   side_reg;
    logic signed [omwsm_pkg::N_W-1:0]   xx_next, yy_next;
    logic [omwsm_pkg::N_W-1:0]          n_next;
    omwsm_pkg::side_t                   side_next;

    always_comb
    begin
        xx_next = s1_reg.stick_x * s1_reg.stick_x;
        yy_next = s1_reg.stick_y * s1_reg.stick_y;
        n_next  = xx_reg + yy_reg;
        for (int i = 0; i < NL; i++)
        begin
            side_next.p[i] = {yc_reg[i][omwsm_pkg::N_W-1], yc_reg[i]}
                           - {xs_reg[i][omwsm_pkg::N_W-1], xs_reg[i]};
        end
        side_next.lim = {32'd0, n_next} > LIM_THR;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= start && !busy;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_reg <= sample;
        xx_reg <= xx_next;
        yy_reg <= yy_next;
        for (int i = 0; i < NL; i++)
        begin
            yc_reg[i] <= s1_reg.stick_y * cos_reg[i];
            xs_reg[i] <= s1_reg.stick_x * sin_reg[i];
        end
        n_reg    <= n_next;
        side_reg <= side_next;
    end

    // ---------------- vector length ----------------
    logic                                vq_out;
    logic [omwsm_pkg::ROOT_W-1:0]        len_out;
    logic [TAG_W-1:0]                    tag_out;
    omwsm_pkg::side_t                    side_q;

    omwsm_sqrt #(
        .NW    (omwsm_pkg::N_W),
        .TAG_W (TAG_W)
    ) u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .vld_in   (v3_reg),
        .n_in     (n_reg),
        .tag_in   (side_reg),
        .vld_out  (vq_out),
        .root_out (len_out),
        .tag_out  (tag_out)
    );

    assign side_q = omwsm_pkg::side_t'(tag_out);

    // ---------------- magnitudes ----------------
    logic                             va_reg, vb_reg;
    logic [NL-1:0][omwsm_pkg::AP_W-1:0] ap_reg;
    logic [NL-1:0]                    nega_reg, negb_reg;
    logic [omwsm_pkg::ROOT_W-1:0]     len_reg;
    logic                             lima_reg, limb_reg;
    logic [NL-1:0][WW-1:0]            m_reg;
    logic [DW-1:0]                    d_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
        end
        else
        begin
            va_reg <= vq_out;
            vb_reg <= va_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < NL; i++)
        begin
            nega_reg[i] <= side_q.p[i][omwsm_pkg::P_W-1];
            ap_reg[i]   <= side_q.p[i][omwsm_pkg::P_W-1]
                         ? omwsm_pkg::AP_W'(-side_q.p[i])
                         : omwsm_pkg::AP_W'(side_q.p[i]);
            m_reg[i]    <= WW'(speed_limit_reg) * WW'(ap_reg[i]);
        end
        len_reg  <= len_out;
        lima_reg <= side_q.lim;
        negb_reg <= nega_reg;
        limb_reg <= lima_reg;
        // unlimited: divide by the full fraction scale, which is a plain shift
        d_reg    <= lima_reg ? (DW'(len_reg) << omwsm_pkg::COEF_FRAC) : (DW'(1) << SHIFT);
    end

    // ---------------- divide and encode ----------------
    logic                                    vd_out;
    logic [NL-1:0][omwsm_pkg::MAG_W:0]       q_out;
    logic [NL-1:0]                           negd_out;
    logic                                    limd_out;
    logic [NL-1:0][omwsm_pkg::CMD_W-1:0]     cmd;
    logic                                    out_vld_reg;
    omwsm_pkg::out_t                         out_reg;

    omwsm_div #(
        .WW (WW),
        .DW (DW)
    ) u_div (
        .clk     (clk),
        .rst_n   (rst_n),
        .vld_in  (vb_reg),
        .m_in    (m_reg),
        .d_in    (d_reg),
        .neg_in  (negb_reg),
        .lim_in  (limb_reg),
        .vld_out (vd_out),
        .q_out   (q_out),
        .neg_out (negd_out),
        .lim_out (limd_out)
    );

    always_comb
    begin
        for (int i = 0; i < NL; i++)
        begin
            logic [omwsm_pkg::MAG_W-1:0] mag;
            mag = q_out[i][omwsm_pkg::MAG_W] ? '1 : q_out[i][omwsm_pkg::MAG_W-1:0];
            // negative speed that truncated to zero is sent as forward zero
            cmd[i] = (negd_out[i] && mag != '0) ? {1'b0, mag} : {1'b1, mag};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_vld_reg <= 1'b0;
        else
            out_vld_reg <= vd_out;
    end

    always_ff @(posedge clk)
    begin
        out_reg.wheel1_cmd  <= cmd[0];
        out_reg.wheel2_cmd  <= cmd[1];
        out_reg.wheel3_cmd  <= cmd[2];
        out_reg.was_limited <= limd_out;
    end

    assign result_valid = out_vld_reg;
    assign result       = out_reg;

    // ---------------- assertions ----------------
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##LATENCY result_valid)
        else $error("beat accepted without result at expected latency");

    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        !(start && !busy) |-> ##LATENCY !result_valid)
        else $error("result without accepted beat");

    a_no_neg_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> ((result.wheel1_cmd[10] || result.wheel1_cmd[9:0] != 0)
                       && (result.wheel2_cmd[10] || result.wheel2_cmd[9:0] != 0)
                       && (result.wheel3_cmd[10] || result.wheel3_cmd[9:0] != 0)))
        else $error("negative zero wheel command");

endmodule

FILE: dv/omwsm_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// omwsm_checker
// Watches the sample, register-write and result channels of the omni wheel
// speed mixer, predicts each result and compares it field by field.
// ----------------------------------------------------------------------------
module omwsm_checker
    import omwsm_pkg::*;
#(
    parameter int INPUT_FRAC_BITS = 14
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic                  busy,
    input  in_t                   sample,
    input  logic                  wr_en,
    input  logic [CFG_IDX_W-1:0]  wr_index,
    input  logic [CFG_DATA_W-1:0] wr_data,
    input  logic                  result_valid,
    input  out_t                  result,
    output int                    fail_count,
    output int                    pending
);

    logic [SL_W-1:0]          speed_limit;
    logic signed [COEF_W-1:0] wheel_cos [NUM_WHEELS];
    logic signed [COEF_W-1:0] wheel_sin [NUM_WHEELS];
    out_t                     cmd_queue [$];

    assign pending = cmd_queue.size();

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("%0t mismatch %s: got %0d expected %0d", $realtime, what, got, want);
        fail_count++;
    endtask

    function automatic logic [63:0] int_sqrt(input logic [63:0] n);
        logic [63:0] root;
        logic [63:0] rem;
        logic [63:0] bit_v;
        root  = 0;
        rem   = n;
        bit_v = 64'd1 << 62;
        while (bit_v > rem)
            bit_v >>= 2;
        while (bit_v != 0)
        begin
            if (rem >= root + bit_v)
            begin
                rem  = rem - (root + bit_v);
                root = (root >> 1) + bit_v;
            end
            else
                root >>= 1;
            bit_v >>= 2;
        end
        return root;
    endfunction

    function automatic out_t mix_wheels(input in_t s);
        out_t                o;
        longint              x;
        longint              y;
        longint              p;
        logic [63:0]         n;
        logic [63:0]         len;
        logic [63:0]         m;
        logic [63:0]         mag;
        logic [CMD_W-1:0]    cmd [NUM_WHEELS];
        bit                  lim;
        x   = s.stick_x;
        y   = s.stick_y;
        n   = x * x + y * y;
        lim = n > (64'd1 << (2 * INPUT_FRAC_BITS));
        len = lim ? int_sqrt(n) : 64'd1;
        for (int i = 0; i < NUM_WHEELS; i++)
        begin
            p = y * longint'(wheel_cos[i]) - x * longint'(wheel_sin[i]);
            m = 64'(speed_limit) * 64'(p < 0 ? -p : p);
            if (lim)
                mag = m / (len << COEF_FRAC);
            else
                mag = m >> (INPUT_FRAC_BITS + COEF_FRAC);
            if (mag > 1023)
                mag = 1023;
            if (p < 0 && mag != 0)
                cmd[i] = CMD_W'(mag);
            else
                cmd[i] = CMD_W'(1024 + mag);
        end
        o.wheel1_cmd  = cmd[0];
        o.wheel2_cmd  = cmd[1];
        o.wheel3_cmd  = cmd[2];
        o.was_limited = lim;
        return o;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        out_t want;
        if (!rst_n)
        begin
            speed_limit  <= SPEED_LIMIT_RST;
            wheel_cos[0] <= W1_COS_RST;
            wheel_sin[0] <= W1_SIN_RST;
            wheel_cos[1] <= W2_COS_RST;
            wheel_sin[1] <= W2_SIN_RST;
            wheel_cos[2] <= W3_COS_RST;
            wheel_sin[2] <= W3_SIN_RST;
            fail_count   <= 0;
            cmd_queue.delete();
        end
        else
        begin
            // result first so a same-edge sample is queued behind it
            if (result_valid)
            begin
                if (cmd_queue.size() == 0)
                begin
                    $display("%0t unexpected result beat", $realtime);
                    fail_count++;
                end
                else
                begin
                    want = cmd_queue.pop_front();
                    if (result.wheel1_cmd !== want.wheel1_cmd)
                        report_mismatch("wheel1_cmd", result.wheel1_cmd, want.wheel1_cmd);
                    if (result.wheel2_cmd !== want.wheel2_cmd)
                        report_mismatch("wheel2_cmd", result.wheel2_cmd, want.wheel2_cmd);
                    if (result.wheel3_cmd !== want.wheel3_cmd)
                        report_mismatch("wheel3_cmd", result.wheel3_cmd, want.wheel3_cmd);
                    if (result.was_limited !== want.was_limited)
                        report_mismatch("was_limited", result.was_limited,
                                        want.was_limited);
                end
            end
            if (start && !busy)
                cmd_queue.push_back(mix_wheels(sample));
            if (wr_en)
            begin
                case (reg_idx_t'(wr_index))
                    REG_SPEED_LIMIT: speed_limit  <= wr_data[SL_W-1:0];
                    REG_WHEEL1_COS:  wheel_cos[0] <= wr_data;
                    REG_WHEEL1_SIN:  wheel_sin[0] <= wr_data;
                    REG_WHEEL2_COS:  wheel_cos[1] <= wr_data;
                    REG_WHEEL2_SIN:  wheel_sin[1] <= wr_data;
                    REG_WHEEL3_COS:  wheel_cos[2] <= wr_data;
                    REG_WHEEL3_SIN:  wheel_sin[2] <= wr_data;
                    default: ;
                endcase
            end
        end
    end

endmodule

FILE: dv/tb_omni_wheel_speed_mixer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_omni_wheel_speed_mixer
// Drives corner and random-burst joystick samples under several register
// settings and lets the checker predict and compare every wheel command beat.
// ----------------------------------------------------------------------------
module tb_omni_wheel_speed_mixer;
    import omwsm_pkg::*;

    localparam int LATENCY = 33;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  start = 1'b0;
    logic                  busy;
    in_t                   sample = '0;
    logic                  wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  wr_index = '0;
    logic [CFG_DATA_W-1:0] wr_data = '0;
    logic                  result_valid;
    out_t                  result;
    int                    fail_count;
    int                    pending;

    always #2 clk = ~clk;

    omni_wheel_speed_mixer dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .sample(sample),
        .wr_en(wr_en), .wr_index(wr_index), .wr_data(wr_data),
        .result_valid(result_valid), .result(result)
    );

    omwsm_checker chk (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .sample(sample),
        .wr_en(wr_en), .wr_index(wr_index), .wr_data(wr_data),
        .result_valid(result_valid), .result(result),
        .fail_count(fail_count), .pending(pending)
    );

    task automatic write_reg(input reg_idx_t idx, input logic [CFG_DATA_W-1:0] val);
        @(negedge clk);
        wr_en    <= 1'b1;
        wr_index <= idx;
        wr_data  <= val;
        @(negedge clk);
        wr_en    <= 1'b0;
    endtask

    // hold one sample until the block takes it; start stays high between beats if keep is set
    task automatic send_stick(input logic [15:0] x, input logic [15:0] y, input bit keep);
        start  <= 1'b1;
        sample <= {x, y};
        do
            @(posedge clk);
        while (busy);
        @(negedge clk);
        if (!keep)
        begin
            start <= 1'b0;
            @(negedge clk);
        end
    endtask

    task automatic drain();
        while (pending != 0)
            @(negedge clk);
        repeat (LATENCY + 4) @(negedge clk);
    endtask

    function automatic logic [15:0] rand_coef();
        case ($urandom_range(0, 5))
            0: return 16'sd16384;
            1: return -16'sd16384;
            2: return 16'h8000;
            3: return 16'h7fff;
            default: return 16'($urandom_range(0, 32768)) - 16'd16384;
        endcase
    endfunction

    function automatic logic [15:0] rand_axis();
        case ($urandom_range(0, 7))
            0: return 16'h8000;
            1: return 16'h7fff;
            2: return 16'($urandom_range(0, 64)) - 16'd32;
            3, 4: return 16'($urandom_range(0, 32768)) - 16'd16384;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic random_run(input int count);
        int left;
        int burst;
        left = count;
        while (left > 0)
        begin
            burst = $urandom_range(1, 24);
            for (int b = 0; b < burst && left > 0; b++, left--)
                send_stick(rand_axis(), rand_axis(), b < burst - 1 && left > 1);
            if ($urandom_range(0, 3) != 0)
                repeat ($urandom_range(1, 40)) @(negedge clk);
        end
    endtask

    initial
    begin
        logic [15:0] corner [6];
        corner = '{16'h8000, 16'h7fff, 16'h0000, 16'h4000, 16'hc000, 16'h0001};
        repeat (4) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        // reset coefficients, directed corners incl. zero vector and unit edge
        for (int i = 0; i < 6; i++)
            for (int j = 0; j < 4; j++)
                send_stick(corner[i], corner[j], 1'b0);
        drain();
        // overflowing coefficients, max speed
        write_reg(REG_SPEED_LIMIT, 16'd1023);
        write_reg(REG_WHEEL1_COS, 16'h8000);
        write_reg(REG_WHEEL1_SIN, 16'h7fff);
        write_reg(REG_WHEEL2_COS, 16'sd16384);
        write_reg(REG_WHEEL2_SIN, -16'sd16384);
        write_reg(REG_WHEEL3_COS, 16'hffff);
        write_reg(REG_WHEEL3_SIN, 16'h0000);
        random_run(300);
        drain();
        write_reg(REG_SPEED_LIMIT, 16'd0);
        random_run(100);
        drain();
        for (int phase = 0; phase < 6; phase++)
        begin
            write_reg(REG_SPEED_LIMIT, 16'($urandom_range(0, 1023)));
            write_reg(REG_WHEEL1_COS, rand_coef());
            write_reg(REG_WHEEL1_SIN, rand_coef());
            write_reg(REG_WHEEL2_COS, rand_coef());
            write_reg(REG_WHEEL2_SIN, rand_coef());
            write_reg(REG_WHEEL3_COS, rand_coef());
            write_reg(REG_WHEEL3_SIN, rand_coef());
            random_run(250);
            drain();
        end
        if (fail_count == 0)
            $display("** omni_wheel_speed_mixer: PASSED **");
        else
            $display("** omni_wheel_speed_mixer: FAILED **");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("** omni_wheel_speed_mixer: FAILED **");
        $finish;
    end

endmodule

FILE: filelist.f
sv/omwsm_pkg.sv
sv/omwsm_sqrt.sv
sv/omwsm_div.sv
sv/omni_wheel_speed_mixer.sv
dv/omwsm_checker.sv
dv/tb_omni_wheel_speed_mixer.sv
